// ===== hdl/osset_pkg.sv =====
// osset_pkg: shared types and constants for the order statistic set
// operation and status codes, fixed port widths, shift command of a cell
// no dependencies
`timescale 1ns / 1ps

package osset_pkg;

	localparam int OPERAND_W   = 32;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 3;
	localparam int OCC_W       = 9;
	localparam int OP_W        = 2;

	localparam int DEF_CAPACITY = 256;
	localparam int DEF_KEY_BITS = 32;
	localparam int DEF_GROUP    = 16;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SELECT = 2'd2,
		OP_RANK   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_PRESENT = 3'd1,
		ST_ABSENT  = 3'd2,
		ST_RANGE   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	// shift request broadcast to every cell in the commit cycle
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

// ===== hdl/osset_cell.sv =====
// osset_cell: one slot of the sorted row; holds a key, compares it with the
// broadcast key and shifts left or right with its neighbors
// depends on osset_pkg
`timescale 1ns / 1ps

module osset_cell #(
	parameter int INDEX    = 0,
	parameter int KEY_BITS = 32,
	parameter int IDX_W    = 8,
	parameter int CNT_W    = 9,
	parameter int WORD_W   = 32
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [IDX_W-1:0]      sel_index,
	input  logic                  is_select,
	input  logic [CNT_W-1:0]      count,
	input  osset_pkg::cell_cmd_t  cmd,
	input  logic [KEY_BITS-1:0]   ins_key,
	input  logic                  left_lt,
	input  logic [KEY_BITS-1:0]   left_key,
	input  logic [KEY_BITS-1:0]   right_key,
	output logic [KEY_BITS-1:0]   stored_key,
	output logic                  lt,
	output logic                  eq,
	output logic [WORD_W-1:0]     word
);
	import osset_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic                lt_q;
	logic                eq_q;
	logic [WORD_W-1:0]   word_q;
	logic                occ;
	logic                lt_c;
	logic                eq_c;

	assign occ  = CNT_W'(INDEX) < count;
	assign lt_c = occ && ($signed(key_q) < $signed(key));
	assign eq_c = occ && (key_q == key);

	always_ff @(posedge clk) begin
		if (load) begin
			lt_q <= lt_c;
			eq_q <= eq_c;
			// select hit carries the key, rank hit carries the 1-based position
			if (is_select) begin
				word_q <= (sel_index == IDX_W'(INDEX)) ? WORD_W'(key_q) : '0;
			end else begin
				word_q <= eq_c ? WORD_W'(CNT_W'(INDEX + 1)) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !lt_q) begin
			key_q <= left_lt ? ins_key : left_key;
		end else if (cmd.del && !lt_q) begin
			key_q <= right_key;
		end
	end

	assign stored_key = key_q;
	assign lt         = lt_q;
	assign eq         = eq_q;
	assign word       = word_q;

endmodule

// ===== hdl/osset_reduce.sv =====
// osset_reduce: registered two-level or-tree over the cell match flags and
// hit words; each group is folded and registered, and the registered group results are then combined
// depends on osset_pkg
`timescale 1ns / 1ps

module osset_reduce #(
	parameter int N     = 256,
	parameter int W     = 32,
	parameter int GROUP = osset_pkg::DEF_GROUP
) (
	input  logic          clk,
	input  logic          load,
	input  logic [N-1:0]  eq,
	input  logic [W-1:0]  word [N],
	output logic          found,
	output logic [W-1:0]  word_or
);
	import osset_pkg::*;

	localparam int NGRP = (N + GROUP - 1) / GROUP;

	logic [NGRP-1:0] grp_eq_q;
	logic [W-1:0]    grp_word_q [NGRP];
	logic [NGRP-1:0] grp_eq_c;
	logic [W-1:0]    grp_word_c [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_eq_c[g]   = 1'b0;
			grp_word_c[g] = '0;
			for (int j = 0; j < GROUP; j++) begin
				if (g * GROUP + j < N) begin
					grp_eq_c[g]   = grp_eq_c[g] | eq[g * GROUP + j];
					grp_word_c[g] = grp_word_c[g] | word[g * GROUP + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_eq_q   <= grp_eq_c;
			grp_word_q <= grp_word_c;
		end
	end

	always_comb begin
		word_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			word_or = word_or | grp_word_q[g];
		end
	end

	assign found = |grp_eq_q;

endmodule

// ===== hdl/order_statistic_set_core.sv =====
// order_statistic_set_core: sorted set of distinct signed keys with insert,
// delete, select by position and rank, built as a row of compare/shift cells
// depends on osset_pkg, osset_cell, osset_reduce
//
//   channel  signals                                  dir  meaning
//   req      req_valid req_ready operation operand    in   one operation word
//   rsp      rsp_valid rsp_ready value status occupancy out  one result word
//
// on a request all cells compare against the key, the match flags and hit
// words are folded by a registered or-tree, then the result is formed and
// the row shifts; one request is in flight at a time. reset clears the
// element count and the control state; key slots and the value, status and
// occupancy outputs keep their value. a result waiting on rsp_ready holds
// the commit step, the request that produced it is already taken.
`timescale 1ns / 1ps

module order_statistic_set_core #(
	parameter int CAPACITY = osset_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = osset_pkg::DEF_KEY_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [osset_pkg::OP_W-1:0]          operation,
	input  logic signed [osset_pkg::OPERAND_W-1:0] operand,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic signed [osset_pkg::VALUE_W-1:0] value,
	output logic [osset_pkg::STATUS_W-1:0]      status,
	output logic [osset_pkg::OCC_W-1:0]         occupancy
);
	import osset_pkg::*;

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int WORD_W = (KEY_BITS > CNT_W) ? KEY_BITS : CNT_W;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_REDUCE = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [OPERAND_W-1:0]   operand_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [CNT_W-1:0]       count_q;
	logic                   rsp_valid_q;
	logic [VALUE_W-1:0]     value_q;
	status_t                status_q;
	logic [OCC_W-1:0]       occ_q;

	logic                   accept;
	logic                   fire;
	logic [63:0]            operand_wide;
	logic [KEY_BITS-1:0]    key_in;
	logic [IDX_W-1:0]       sel_index;
	logic                   is_select;
	cell_cmd_t              cmd;

	logic [KEY_BITS-1:0]    cell_key [CAPACITY];
	logic [CAPACITY-1:0]    cell_lt;
	logic [CAPACITY-1:0]    cell_eq;
	logic [WORD_W-1:0]      cell_word [CAPACITY];

	logic                   found;
	logic [WORD_W-1:0]      hit_word;

	logic                   full;
	logic                   sel_ok;
	logic signed [63:0]     sel_ext;
	logic [CNT_W-1:0]       count_next;
	logic [VALUE_W-1:0]     value_next;
	status_t                status_next;
	logic [31:0]            count_wide;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign fire      = (state_q == S_COMMIT) && (!rsp_valid_q || rsp_ready);

	// keys wider than the operand take it zero-extended
	assign operand_wide = {32'd0, operand};
	assign key_in       = operand_wide[KEY_BITS-1:0];
	assign sel_index    = operand[IDX_W-1:0] - IDX_W'(1);
	assign is_select    = (op_t'(operation) == OP_SELECT);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                left_lt;
		logic [KEY_BITS-1:0] left_key;
		logic [KEY_BITS-1:0] right_key;

		if (i == 0) begin : g_first
			assign left_lt  = 1'b0;
			assign left_key = key_q;
		end else begin : g_mid
			assign left_lt  = cell_lt[i-1];
			assign left_key = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_key = cell_key[i];
		end else begin : g_inner
			assign right_key = cell_key[i+1];
		end

		osset_cell #(
			.INDEX    (i),
			.KEY_BITS (KEY_BITS),
			.IDX_W    (IDX_W),
			.CNT_W    (CNT_W),
			.WORD_W   (WORD_W)
		) u_cell (
			.clk        (clk),
			.load       (accept),
			.key        (key_in),
			.sel_index  (sel_index),
			.is_select  (is_select),
			.count      (count_q),
			.cmd        (cmd),
			.ins_key    (key_q),
			.left_lt    (left_lt),
			.left_key   (left_key),
			.right_key  (right_key),
			.stored_key (cell_key[i]),
			.lt         (cell_lt[i]),
			.eq         (cell_eq[i]),
			.word       (cell_word[i])
		);
	end

	osset_reduce #(
		.N     (CAPACITY),
		.W     (WORD_W),
		.GROUP (DEF_GROUP)
	) u_reduce (
		.clk     (clk),
		.load    (state_q == S_REDUCE),
		.eq      (cell_eq),
		.word    (cell_word),
		.found   (found),
		.word_or (hit_word)
	);

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign sel_ok  = !operand_q[OPERAND_W-1] && (operand_q != '0)
		&& (operand_q <= 32'(count_q));
	assign sel_ext = 64'($signed(hit_word[KEY_BITS-1:0]));

	always_comb begin
		count_next  = count_q;
		value_next  = '0;
		status_next = ST_OK;
		cmd         = '0;
		unique case (op_q)
			OP_INSERT: begin
				if (found) begin
					status_next = ST_PRESENT;
				end else if (full) begin
					status_next = ST_FULL;
				end else begin
					cmd.ins    = fire;
					count_next = count_q + CNT_W'(1);
					value_next = operand_q;
				end
			end
			OP_DELETE: begin
				if (!found) begin
					status_next = ST_ABSENT;
				end else begin
					cmd.del    = fire;
					count_next = count_q - CNT_W'(1);
					value_next = operand_q;
				end
			end
			OP_SELECT: begin
				if (!sel_ok) begin
					status_next = ST_RANGE;
				end else begin
					value_next = sel_ext[VALUE_W-1:0];
				end
			end
			OP_RANK: begin
				if (!found) begin
					status_next = ST_ABSENT;
				end else begin
					value_next = 32'(hit_word[CNT_W-1:0]);
				end
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	assign count_wide = 32'(count_next);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(operation);
			operand_q <= operand;
			key_q     <= key_in;
		end
		if (fire) begin
			value_q  <= value_next;
			status_q <= status_next;
			occ_q    <= count_wide[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;
	assign status    = status_q;
	assign occupancy = occ_q;

endmodule
